// File: design/mwdds_pkg.sv
// Shared types, constants and ROM-build functions for the DDS tone generator.
// Depends on nothing; every other module of the block imports it.
package mwdds_pkg;

   // Default sizes
   localparam int PHASE_BITS_DEF       = 32;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;
   localparam int SAMPLE_BITS_DEF      = 32;
   localparam int QUEUE_DEPTH          = 4;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_TUNING_WORD = 2'd0;
   localparam logic [1:0] CSR_WAVE_SELECT = 2'd1;
   localparam logic [1:0] CSR_VOLUME_GAIN = 2'd2;

   // Wave select codes
   typedef enum logic [1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_TRIANGLE = 2'd2,
      WAVE_SAWTOOTH = 2'd3
   } wave_type;

   // Register limits and reset values
   localparam logic [31:0] TUNING_MIN   = 32'd97392;
   localparam logic [31:0] TUNING_MAX   = 32'd2147483648;
   localparam logic [31:0] TUNING_RESET = 32'd42852281;
   localparam logic [16:0] VOLUME_MAX   = 17'd65536;
   localparam logic [16:0] VOLUME_RESET = 17'd32768;

   // pi/2 in unsigned Q4.60
   localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

   // Taylor term divisors (2k)(2k+1), k = 1..14
   localparam logic [9:0] TAYLOR_DIV [14] = '{
      10'd6,   10'd20,  10'd42,  10'd72,  10'd110, 10'd156, 10'd210,
      10'd272, 10'd342, 10'd420, 10'd506, 10'd600, 10'd702, 10'd812
   };

   // Front to queue: one phase snapshot per tick beat
   typedef struct packed {
      logic        valid;
      logic [31:0] phase;
   } phase_push_type;

   // Queue to back: head entry and its valid bit
   typedef struct packed {
      logic        valid;
      logic [31:0] phase;
   } phase_head_type;

   // (a * b) >> 60, truncated to 64 bits
   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[123:60];
   endfunction

   // sin(x) for x in Q4.60 by a 15-term Taylor series, rounded to Q1.31, capped at 1.0
   function automatic logic [31:0] sine_from_x(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      x2   = mul_q60(x, x);
      term = x;
      sum  = x;
      for (int k = 0; k < 14; k++) begin
         term = mul_q60(term, x2) / 64'(TAYLOR_DIV[k]);
         if (k[0] == 1'b0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      v = (sum + 64'h10000000) >> 29;
      if (v > 64'h80000000) begin
         v = 64'h80000000;
      end
      return v[31:0];
   endfunction

endpackage

// File: design/mwdds_front.sv
// Front end: accepts tick beats, drops idle ticks, snapshots the phase and steps it.
// Depends on mwdds_pkg.
module mwdds_front
   import mwdds_pkg::*;
#(
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           tick,
   input  logic [31:0]    tuning_word,
   input  logic           queue_full,
   output phase_push_type push
);

   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS-1:0] increment;
   logic [31:0]           phase_top;
   logic [63:0]           tuning64;
   logic [63:0]           phase64;
   logic                  take;

   assign tuning64 = 64'(tuning_word);
   assign phase64  = 64'(phase_ff);

   // Align the tuning word and the phase window to the accumulator width
   if (PHASE_BITS >= 32) begin : g_wide
      assign increment = PHASE_BITS'(tuning64 << (PHASE_BITS - 32));
      assign phase_top = 32'(phase64 >> (PHASE_BITS - 32));
   end else begin : g_narrow
      assign increment = PHASE_BITS'(tuning64 >> (32 - PHASE_BITS));
      assign phase_top = 32'(phase64 << (32 - PHASE_BITS));
   end

   // Ready only on queue room; a tick of zero is taken and dropped
   assign req_tready = !queue_full;
   assign take       = req_tvalid && req_tready && tick;

   assign push.valid = take;
   assign push.phase = phase_top;

   assign phase_in = take ? phase_ff + increment : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// File: design/mwdds_queue.sv
// Short phase queue between front and back so each side stalls on its own.
// Depends on mwdds_pkg.
module mwdds_queue
   import mwdds_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  phase_push_type push,
   input  logic           pop,
   output phase_head_type head,
   output logic           full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [31:0]      store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.phase = store_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   // Pointer and fill-count update
   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         store_ff[wr_ptr_ff] <= push.phase;
      end
   end

endmodule

// File: design/mwdds_back.sv
// Back end: waveform, sine ROM lookup, volume scaling, saturation and result register.
// Depends on mwdds_pkg (ROM-build function, wave codes, head type).
module mwdds_back
   import mwdds_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  phase_head_type head,
   output logic           pop,
   input  wave_type       wave_select,
   input  logic [16:0]    volume_gain,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [31:0]    rsp_sample
);

   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PROD_W = 31 + IDX_W;
   localparam int DROP   = 32 - SAMPLE_BITS;
   localparam logic [31:0] KEEP_MASK = ~((32'(1) << DROP) - 32'(1));

   // Quarter-wave sine ROM, built at elaboration
   logic [31:0] sine_rom [SINE_TABLE_DEPTH + 1];

   for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
      localparam logic [63:0] X = (HALF_PI_Q60 / SINE_TABLE_DEPTH) * 64'(g)
         + ((HALF_PI_Q60 % SINE_TABLE_DEPTH) * 64'(g)) / SINE_TABLE_DEPTH;
      assign sine_rom[g] = sine_from_x(X);
   end

   logic advance;

   // Stage 1: wave shape and sine index
   logic                v1_ff;
   logic                sine1_ff, sine1_in;
   logic                neg1_ff, neg1_in;
   logic [IDX_W-1:0]    idx1_ff, idx1_in;
   logic signed [32:0]  wave1_ff, wave1_in;
   logic [31:0]         p;
   logic [30:0]         pos;
   logic [PROD_W-1:0]   idx_prod;
   logic [IDX_W-1:0]    idx_raw;
   logic signed [33:0]  tri_up, tri_down;

   // Stage 2: ROM data and chosen wave value
   logic                v2_ff;
   logic                sine2_ff;
   logic                neg2_ff;
   logic [31:0]         rom2_ff;
   logic signed [32:0]  wave2_ff;
   logic signed [32:0]  w2;

   // Stage 3: volume product
   logic                v3_ff;
   logic signed [50:0]  prod3_ff, prod3_in;

   // Result register
   logic                out_valid_ff;
   logic [31:0]         out_sample_ff, out_sample_in;
   logic signed [50:0]  prod_adj;
   logic signed [34:0]  scaled;
   logic [31:0]         sat;

   // Whole pipeline moves together when the result slot frees up
   assign advance = !out_valid_ff || rsp_tready;
   assign pop     = advance;

   // Stage 1 logic
   always_comb begin
      p        = head.phase;
      pos      = p[30] ? 31'h40000000 - 31'(p[29:0]) : 31'(p[29:0]);
      idx_prod = PROD_W'(pos) * PROD_W'(SINE_TABLE_DEPTH);
      idx_raw  = idx_prod[30 +: IDX_W];
      idx1_in  = (idx_raw > IDX_W'(SINE_TABLE_DEPTH)) ? IDX_W'(SINE_TABLE_DEPTH) : idx_raw;
      neg1_in  = p[31];
      sine1_in = (wave_select == WAVE_SINE);
      tri_up   = 34'sd2 * $signed({2'b00, p}) - 34'sh080000000;
      tri_down = 34'sh180000000 - 34'sd2 * $signed({2'b00, p});
      unique case (wave_select)
         WAVE_SQUARE:   wave1_in = p[31] ? -33'sh080000000 : 33'sh080000000;
         WAVE_TRIANGLE: wave1_in = p[31] ? 33'(tri_down) : 33'(tri_up);
         WAVE_SAWTOOTH: wave1_in = $signed({~p[31], ~p[31], p[30:0]});
         default:       wave1_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sine1_ff <= sine1_in;
         neg1_ff  <= neg1_in;
         idx1_ff  <= idx1_in;
         wave1_ff <= wave1_in;
         sine2_ff <= sine1_ff;
         neg2_ff  <= neg1_ff;
         wave2_ff <= wave1_ff;
         rom2_ff  <= sine_rom[idx1_ff];
         prod3_ff <= prod3_in;
      end
   end

   // Stage 2 logic: signed sine or the precomputed shape, times gain
   always_comb begin
      if (sine2_ff) begin
         w2 = neg2_ff ? -$signed({1'b0, rom2_ff}) : $signed({1'b0, rom2_ff});
      end else begin
         w2 = wave2_ff;
      end
      prod3_in = 51'(w2) * 51'($signed({1'b0, volume_gain}));
   end

   // Stage 3 logic: shift toward zero, saturate, clear dropped bits
   always_comb begin
      prod_adj = prod3_ff + (prod3_ff[50] ? 51'sd65535 : 51'sd0);
      scaled   = 35'(prod_adj >>> 16);
      if (scaled > 35'sh07FFFFFFF) begin
         sat = 32'h7FFFFFFF;
      end else if (scaled < -35'sh080000000) begin
         sat = 32'h80000000;
      end else begin
         sat = scaled[31:0];
      end
      out_sample_in = sat & KEEP_MASK;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_sample_ff <= out_sample_in;
      end
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= head.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_sample = out_sample_ff;

endmodule

// File: design/multi_waveform_dds_generator_core.sv
// Direct digital synthesis tone generator: one stereo sample per tick beat taken on req_.
// Each sample is taken from the current phase, then the phase advances by the tuning word;
// sine, square, triangle or sawtooth, scaled by a Q1.16 volume and saturated to Q1.31.
// One tick beat is accepted every clock cycle while the queue has room; a sample passes
// front snapshot, queue, shape stage, sine ROM read, volume multiply and result register,
// and the pipeline advances whenever the result register is empty or being taken, so
// the 33x17 volume multiplier and the registered sine ROM read set the cycle time.
// A tick of zero is accepted and makes no sample. Write the csr registers only while idle.
// Depends on mwdds_pkg, mwdds_front, mwdds_queue, mwdds_back.
module multi_waveform_dds_generator_core
   import mwdds_pkg::*;
#(
   parameter int PHASE_BITS       = PHASE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // tick beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] tick, [7:1] zero
   // sample beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] left_sample, [63:32] right_sample
   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   logic [31:0]    tuning_ff, tuning_in;
   wave_type       wave_ff, wave_in;
   logic [16:0]    gain_ff, gain_in;
   logic [16:0]    gain_raw;
   phase_push_type push;
   phase_head_type head;
   logic           queue_full;
   logic           pop;
   logic [31:0]    sample;

   // Register writes with range clamps
   always_comb begin
      tuning_in = tuning_ff;
      wave_in   = wave_ff;
      gain_in   = gain_ff;
      gain_raw  = csr_wdata[16:0];
      if (csr_we) begin
         if (csr_addr == CSR_TUNING_WORD) begin
            if (csr_wdata < TUNING_MIN) begin
               tuning_in = TUNING_MIN;
            end else if (csr_wdata > TUNING_MAX) begin
               tuning_in = TUNING_MAX;
            end else begin
               tuning_in = csr_wdata;
            end
         end else if (csr_addr == CSR_WAVE_SELECT) begin
            wave_in = wave_type'(csr_wdata[1:0]);
         end else if (csr_addr == CSR_VOLUME_GAIN) begin
            gain_in = (gain_raw > VOLUME_MAX) ? VOLUME_MAX : gain_raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tuning_ff <= TUNING_RESET;
         wave_ff   <= WAVE_SINE;
         gain_ff   <= VOLUME_RESET;
      end else begin
         tuning_ff <= tuning_in;
         wave_ff   <= wave_in;
         gain_ff   <= gain_in;
      end
   end

   mwdds_front #(
      .PHASE_BITS(PHASE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .tick        (req_tdata[0]),
      .tuning_word (tuning_ff),
      .queue_full  (queue_full),
      .push        (push)
   );

   mwdds_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   mwdds_back #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .wave_select (wave_ff),
      .volume_gain (gain_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_sample  (sample)
   );

   // Left and right carry the same sample
   assign rsp_tdata = {sample, sample};

endmodule

// File: tb/sv/multi_waveform_dds_generator_core_tb.sv
// Self-checking testbench for the DDS tone generator core: random tick beats and register
// settings, samples predicted in-bench and compared beat by beat. Depends on mwdds_pkg.
`timescale 1ns / 100ps

module multi_waveform_dds_generator_core_tb;
   import mwdds_pkg::*;

   localparam int          SINE_DEPTH  = SINE_TABLE_DEPTH_DEF;
   localparam logic [1:0]  CSR_UNUSED  = 2'd3;
   localparam int          STALL_LIMIT = 1000;
   localparam int          DRAIN       = 16;
   localparam int          MAX_REPORTS = 10;

   typedef struct packed {
      logic [31:0] left;
      logic [31:0] right;
   } stereo_sample;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [0] tick, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;    // [31:0] left_sample, [63:32] right_sample
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [31:0] csr_wdata;

   // predictor state
   logic [31:0]  tone_phase;
   logic [31:0]  tone_step;
   wave_type     tone_wave;
   logic [16:0]  tone_volume;
   logic [31:0]  sine_quarter [0:SINE_DEPTH];
   stereo_sample pending_samples [$];

   int  mismatch_count;
   int  quiet_cycles;
   bit  src_idle_on;
   bit  rsp_stall_on;

   multi_waveform_dds_generator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   // (a * b) >> 60, kept to 64 bits
   function automatic logic [63:0] fixmul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] full;
      full = {64'd0, a} * {64'd0, b};
      return full[123:60];
   endfunction

   // quarter-wave table entry: Taylor series of sin in Q4.60, rounded to Q1.31
   function automatic logic [31:0] quarter_sine_entry(input int unsigned i);
      logic [63:0] depth;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] rounded;
      depth = 64'(SINE_DEPTH);
      x     = (HALF_PI_Q60 / depth) * 64'(i) + ((HALF_PI_Q60 % depth) * 64'(i)) / depth;
      x2    = fixmul_q60(x, x);
      term  = x;
      acc   = x;
      for (int k = 1; k <= 14; k++) begin
         term = fixmul_q60(term, x2) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      rounded = (acc + 64'h1000_0000) >> 29;
      if (rounded > 64'h8000_0000) begin
         rounded = 64'h8000_0000;
      end
      return rounded[31:0];
   endfunction

   // waveform value in Q1.31 (1.0 = 2^31) at phase p
   function automatic longint wave_level(input logic [31:0] p);
      longint      half;
      longint      pl;
      longint      v;
      logic [63:0] pos;
      logic [63:0] idx;
      half = 64'd2147483648;
      pl   = longint'({32'd0, p});
      case (tone_wave)
         WAVE_SINE: begin
            pos = p[30] ? (64'h4000_0000 - 64'(p[29:0])) : 64'(p[29:0]);
            idx = (pos * 64'(SINE_DEPTH)) >> 30;
            if (idx > 64'(SINE_DEPTH)) begin
               idx = 64'(SINE_DEPTH);
            end
            v = longint'({32'd0, sine_quarter[idx]});
            return p[31] ? -v : v;
         end
         WAVE_SQUARE:   return p[31] ? -half : half;
         WAVE_TRIANGLE: return p[31] ? (3 * half - 2 * pl) : (2 * pl - half);
         default:       return pl - half;
      endcase
   endfunction

   // sample for the current phase, then advance the phase
   function automatic logic [31:0] next_sample();
      longint prod;
      longint scaled;
      prod = wave_level(tone_phase) * longint'({47'd0, tone_volume});
      if (prod < 0) begin
         scaled = -((-prod) >>> 16);
      end else begin
         scaled = prod >>> 16;
      end
      if (scaled > 64'sd2147483647) begin
         scaled = 64'sd2147483647;
      end else if (scaled < -64'sd2147483648) begin
         scaled = -64'sd2147483648;
      end
      tone_phase = tone_phase + tone_step;
      return scaled[31:0];
   endfunction

   // register writes and tick beats update the predictor at the edge they take effect
   always @(posedge clock) begin : track_inputs
      logic [31:0] sample;
      logic [16:0] gain;
      if (reset) begin
         tone_phase  = '0;
         tone_step   = TUNING_RESET;
         tone_wave   = WAVE_SINE;
         tone_volume = VOLUME_RESET;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_TUNING_WORD: begin
                  if (csr_wdata < TUNING_MIN) begin
                     tone_step = TUNING_MIN;
                  end else if (csr_wdata > TUNING_MAX) begin
                     tone_step = TUNING_MAX;
                  end else begin
                     tone_step = csr_wdata;
                  end
               end
               CSR_WAVE_SELECT: tone_wave = wave_type'(csr_wdata[1:0]);
               CSR_VOLUME_GAIN: begin
                  gain        = csr_wdata[16:0];
                  tone_volume = (gain > VOLUME_MAX) ? VOLUME_MAX : gain;
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready && req_tdata[0]) begin
            sample = next_sample();
            pending_samples.push_back('{left: sample, right: sample});
         end
      end
   end

   // ------------------------------------------------------------------ checking

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   always @(posedge clock) begin : check_samples
      stereo_sample want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            flag_error($sformatf("sample beat with none expected: %h", rsp_tdata));
         end else begin
            want = pending_samples.pop_front();
            if (rsp_tdata[31:0] !== want.left) begin
               flag_error($sformatf("left_sample: expected %0d, got %0d",
                                    $signed(want.left), $signed(rsp_tdata[31:0])));
            end
            if (rsp_tdata[63:32] !== want.right) begin
               flag_error($sformatf("right_sample: expected %0d, got %0d",
                                    $signed(want.right), $signed(rsp_tdata[63:32])));
            end
         end
      end
   end

   // no beat on any port for too long means the block hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------- driving

   // mostly no gap, some short, a few long
   function automatic int pick_gap(input bit enabled);
      int r;
      if (!enabled) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // sample sink: ready drops for random stretches
   initial begin : sample_sink
      int gap;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         gap = pick_gap(rsp_stall_on);
         if (gap > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
      end
   end

   // all driving tasks start and end on a falling edge
   task automatic send_tick(input logic tick);
      int gap;
      gap = pick_gap(src_idle_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, tick};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // drop valid, wait for every sample, then let the block drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
   endtask

   // --------------------------------------------------------------------- tests

   task automatic test_reset_defaults();
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      wait_idle();
   endtask

   // clamps on tuning and volume, unknown index, full-scale peak saturation
   task automatic test_register_limits();
      write_reg(CSR_VOLUME_GAIN, 32'hFFFF_FFFF);
      write_reg(CSR_WAVE_SELECT, 32'(WAVE_SQUARE));
      write_reg(CSR_TUNING_WORD, 32'hFFFF_FFFF);
      write_reg(CSR_UNUSED, $urandom);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      wait_idle();
      write_reg(CSR_TUNING_WORD, 32'd0);
      write_reg(CSR_VOLUME_GAIN, 32'(VOLUME_MAX) + 32'd1);
      send_tick(1'b1);
      send_tick(1'b1);
      wait_idle();
      write_reg(CSR_TUNING_WORD, TUNING_MIN - 32'd1);
      send_tick(1'b1);
      wait_idle();
      write_reg(CSR_TUNING_WORD, TUNING_MAX + 32'd1);
      send_tick(1'b1);
      send_tick(1'b1);
      wait_idle();
   endtask

   // each waveform in quarter-cycle steps at full volume, then ticks at zero volume
   task automatic test_each_waveform();
      wave_type w;
      write_reg(CSR_TUNING_WORD, 32'h4000_0000);
      write_reg(CSR_VOLUME_GAIN, 32'(VOLUME_MAX));
      w = WAVE_SINE;
      repeat (4) begin
         write_reg(CSR_WAVE_SELECT, 32'(w));
         repeat (3) send_tick(1'b1);
         wait_idle();
         w = w.next();
      end
      write_reg(CSR_VOLUME_GAIN, 32'd0);
      send_tick(1'b1);
      send_tick(1'b1);
      wait_idle();
   endtask

   task automatic test_random_settings();
      logic [31:0] value;
      for (int ph = 0; ph < 12; ph++) begin
         src_idle_on  = ($urandom_range(0, 3) != 0);
         rsp_stall_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 5))
            0:       value = $urandom;
            1:       value = $urandom_range(0, 200000);
            2:       value = TUNING_MAX;
            3:       value = TUNING_MIN;
            4:       value = $urandom_range(97392, 50000000);
            default: value = $urandom_range(97392, 32'h8000_0000);
         endcase
         write_reg(CSR_TUNING_WORD, value);
         write_reg(CSR_WAVE_SELECT, ($urandom & ~32'h3) | 32'($urandom_range(0, 3)));
         case ($urandom_range(0, 4))
            0:       value = 32'd0;
            1:       value = 32'(VOLUME_MAX);
            2:       value = $urandom_range(0, 65536);
            3:       value = $urandom;
            default: value = $urandom_range(0, 32'h1FFFF);
         endcase
         write_reg(CSR_VOLUME_GAIN, value);
         if ($urandom_range(0, 2) == 0) begin
            write_reg(CSR_UNUSED, $urandom);
         end
         // about one beat in ten is a zero tick
         repeat (100) send_tick($urandom_range(0, 9) != 0);
         wait_idle();
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_we         = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      src_idle_on    = 1'b1;
      rsp_stall_on   = 1'b1;
      for (int i = 0; i <= SINE_DEPTH; i++) begin
         sine_quarter[i] = quarter_sine_entry(i);
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_limits();
      test_each_waveform();
      test_random_settings();
      wait_idle();

      if (mismatch_count == 0 && pending_samples.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
